@@ rtl/assert_macros.svh @@
// assertion macros shared by the rwps rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off while reset is held
`define RWPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rwps assertion failed");

// concurrent check that also holds during reset
`define RWPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rwps assertion failed");

`endif

@@ rtl/rwps_pkg.sv @@
// shared types and constants of the roulette wheel pair select block
`timescale 1ns / 1ps
`default_nettype none

package rwps_pkg;

    // width of the one-based result indices on the ports
    localparam int OUT_INDEX_BITS = 9;

    // operation codes of an input item
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SELECT = 2'd2
    } t_func;

    // control part of the search token that walks the cell chain
    typedef struct packed {
        logic valid;
        logic found1;
        logic found2;
    } t_scan_flags;

endpackage

`default_nettype wire

@@ rtl/rwps_scaler.sv @@
// shift-add scaler: draw = floor(fraction * total / 2^FRACTION_BITS) for two fractions
`timescale 1ns / 1ps
`default_nettype none

module rwps_scaler #(
    parameter int FRACTION_BITS = 16,
    parameter int TOTAL_BITS    = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [FRACTION_BITS-1:0] i_frac1,
    input  wire logic [FRACTION_BITS-1:0] i_frac2,
    input  wire logic [TOTAL_BITS-1:0]    i_total,
    output logic                          o_done,
    output logic [TOTAL_BITS-1:0]         o_draw1,
    output logic [TOTAL_BITS-1:0]         o_draw2
);

    localparam int AW = FRACTION_BITS + TOTAL_BITS;
    localparam int SW = $clog2(FRACTION_BITS + 1);

    logic [SW-1:0]            r_step;
    logic                     r_done;
    logic [FRACTION_BITS-1:0] r_f1;
    logic [FRACTION_BITS-1:0] r_f2;
    logic [TOTAL_BITS-1:0]    r_total;
    logic [AW-1:0]            r_acc1;
    logic [AW-1:0]            r_acc2;
    logic [AW-1:0]            n_acc1;
    logic [AW-1:0]            n_acc2;

    // one multiplier bit per cycle, msb first
    always_comb begin
        n_acc1 = {r_acc1[AW-2:0], 1'b0} + (r_f1[FRACTION_BITS-1] ? AW'(r_total) : '0);
        n_acc2 = {r_acc2[AW-2:0], 1'b0} + (r_f2[FRACTION_BITS-1] ? AW'(r_total) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            // done pulses with the last step
            r_done <= !i_start && (r_step == SW'(1));
            if (i_start) begin
                r_step  <= SW'(FRACTION_BITS);
                r_f1    <= i_frac1;
                r_f2    <= i_frac2;
                r_total <= i_total;
                r_acc1  <= '0;
                r_acc2  <= '0;
            end else if (r_step != '0) begin
                r_step <= r_step - SW'(1);
                r_f1   <= {r_f1[FRACTION_BITS-2:0], 1'b0};
                r_f2   <= {r_f2[FRACTION_BITS-2:0], 1'b0};
                r_acc1 <= n_acc1;
                r_acc2 <= n_acc2;
            end
        end
    end

    assign o_done  = r_done;
    assign o_draw1 = r_acc1[FRACTION_BITS +: TOTAL_BITS];
    assign o_draw2 = r_acc2[FRACTION_BITS +: TOTAL_BITS];

endmodule

`default_nettype wire

@@ rtl/rwps_cell.sv @@
// one chain cell: holds a prefix sum and tests the passing search token against it
`timescale 1ns / 1ps
`default_nettype none

module rwps_cell #(
    parameter int TOTAL_BITS = 24,
    parameter int INDEX_BITS = 9
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr_en,
    input  wire logic [TOTAL_BITS-1:0]   i_wr_data,
    input  wire logic [INDEX_BITS-1:0]   i_count,
    input  wire logic [TOTAL_BITS-1:0]   i_draw1,
    input  wire logic [TOTAL_BITS-1:0]   i_draw2,
    input  wire rwps_pkg::t_scan_flags   i_flags,
    input  wire logic [INDEX_BITS-1:0]   i_pos,
    input  wire logic [INDEX_BITS-1:0]   i_idx1,
    input  wire logic [INDEX_BITS-1:0]   i_idx2,
    output rwps_pkg::t_scan_flags        o_flags,
    output logic [INDEX_BITS-1:0]        o_pos,
    output logic [INDEX_BITS-1:0]        o_idx1,
    output logic [INDEX_BITS-1:0]        o_idx2
);

    import rwps_pkg::*;

    logic [TOTAL_BITS-1:0] r_prefix;
    t_scan_flags           r_flags;
    logic [INDEX_BITS-1:0] r_pos;
    logic [INDEX_BITS-1:0] r_idx1;
    logic [INDEX_BITS-1:0] r_idx2;
    logic                  w_live;
    logic                  w_hit1;
    logic                  w_hit2;
    logic [INDEX_BITS-1:0] w_next_pos;

    // only entries below the fill count take part
    always_comb begin
        w_next_pos = i_pos + INDEX_BITS'(1);
        w_live     = i_flags.valid && (i_pos < i_count);
        w_hit1     = w_live && !i_flags.found1 && (r_prefix > i_draw1);
        w_hit2     = w_live && !i_flags.found2 && (r_prefix > i_draw2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags.valid  <= i_flags.valid;
            r_flags.found1 <= i_flags.found1 || w_hit1;
            r_flags.found2 <= i_flags.found2 || w_hit2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prefix <= i_wr_data;
        end
        r_pos  <= w_next_pos;
        r_idx1 <= w_hit1 ? w_next_pos : i_idx1;
        r_idx2 <= w_hit2 ? w_next_pos : i_idx2;
    end

    assign o_flags = r_flags;
    assign o_pos   = r_pos;
    assign o_idx1  = r_idx1;
    assign o_idx2  = r_idx2;

endmodule

`default_nettype wire

@@ rtl/roulette_wheel_pair_select.sv @@
// top level of the roulette wheel pair select block
// fitness-proportional selection of a parent pair from a stored population
// input channel: i_in_valid / o_in_ready with i_func, i_fitness_value,
//   i_first_fraction, i_second_fraction; a transfer takes place when both are high
// output channel: o_out_valid / i_out_ready with o_first_index,
//   o_second_index, o_failed; one result per select item only
// clear and append complete in the cycle of their transfer, so one may
//   follow every cycle
// a select runs through the shift-add scaler, then the search token walks
//   all MAX_ENTRIES cells, one cell a cycle, then the pair is adjusted and
//   moved to the output register
// an empty population or a zero total skips the scaler and the search
// the scaler and the chain walk set the select rate; the next item is taken
//   as soon as the result sits in the output register
// reset empties the population (fill count and total to zero); cell
//   contents are not cleared, as no entry at or above the fill count is read
// when the receiver stalls the result is held in the output register and a
//   following select waits with its finished pair until the register frees
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module roulette_wheel_pair_select #(
    parameter int MAX_ENTRIES   = 256,
    parameter int FITNESS_BITS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_func,
    input  wire logic [FITNESS_BITS-1:0]  i_fitness_value,
    input  wire logic [FRACTION_BITS-1:0] i_first_fraction,
    input  wire logic [FRACTION_BITS-1:0] i_second_fraction,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [rwps_pkg::OUT_INDEX_BITS-1:0] o_first_index,
    output logic [rwps_pkg::OUT_INDEX_BITS-1:0] o_second_index,
    output logic                          o_failed
);

    import rwps_pkg::*;

    // prefix sums never overflow this width
    localparam int TW = FITNESS_BITS + $clog2(MAX_ENTRIES);
    // fill count and one-based indices, up to MAX_ENTRIES itself
    localparam int IW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [IW-1:0]             r_count;
    logic [TW-1:0]             r_total;
    logic [IW-1:0]             r_res_first;
    logic [IW-1:0]             r_res_second;
    logic                      r_res_failed;
    logic                      r_out_valid;
    logic [OUT_INDEX_BITS-1:0] r_out_first;
    logic [OUT_INDEX_BITS-1:0] r_out_second;
    logic                      r_out_failed;

    logic                      w_accept;
    logic                      w_not_full;
    logic                      w_empty;
    logic                      w_append_we;
    logic                      w_start;
    logic                      w_out_load;
    logic [TW-1:0]             w_total_sum;
    logic [MAX_ENTRIES-1:0]    w_wr_en;
    logic                      w_draw_done;
    logic [TW-1:0]             w_draw1;
    logic [TW-1:0]             w_draw2;
    logic [IW-1:0]             w_second_adj;

    // token links between cells, element 0 is the chain head
    t_scan_flags               w_flags [0:MAX_ENTRIES];
    logic [IW-1:0]             w_pos   [0:MAX_ENTRIES];
    logic [IW-1:0]             w_idx1  [0:MAX_ENTRIES];
    logic [IW-1:0]             w_idx2  [0:MAX_ENTRIES];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_not_full = (r_count < IW'(MAX_ENTRIES));
    assign w_empty    = (r_count == '0) || (r_total == '0);

    assign w_total_sum = r_total + TW'(i_fitness_value);
    assign w_append_we = w_accept && (t_func'(i_func) == FUNC_APPEND) && w_not_full;
    assign w_start     = w_accept && (t_func'(i_func) == FUNC_SELECT) && !w_empty;
    // finished pair moves out once the output register is free or drains
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    rwps_scaler #(
        .FRACTION_BITS (FRACTION_BITS),
        .TOTAL_BITS    (TW)
    ) u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_frac1 (i_first_fraction),
        .i_frac2 (i_second_fraction),
        .i_total (r_total),
        .o_done  (w_draw_done),
        .o_draw1 (w_draw1),
        .o_draw2 (w_draw2)
    );

    // token enters the head as soon as both draws are ready
    always_comb begin
        w_flags[0].valid  = w_draw_done && (r_state == S_SCALE);
        w_flags[0].found1 = 1'b0;
        w_flags[0].found2 = 1'b0;
        w_pos[0]          = '0;
        w_idx1[0]         = '0;
        w_idx2[0]         = '0;
    end

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        // the new prefix sum lands in the cell at the fill count
        assign w_wr_en[k] = w_append_we && (r_count == IW'(k));

        rwps_cell #(
            .TOTAL_BITS (TW),
            .INDEX_BITS (IW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_wr_en[k]),
            .i_wr_data (w_total_sum),
            .i_count   (r_count),
            .i_draw1   (w_draw1),
            .i_draw2   (w_draw2),
            .i_flags   (w_flags[k]),
            .i_pos     (w_pos[k]),
            .i_idx1    (w_idx1[k]),
            .i_idx2    (w_idx2[k]),
            .o_flags   (w_flags[k+1]),
            .o_pos     (w_pos[k+1]),
            .o_idx1    (w_idx1[k+1]),
            .o_idx2    (w_idx2[k+1])
        );
    end

    // second pick must differ: step up, or down at the last entry
    always_comb begin
        w_second_adj = w_idx2[MAX_ENTRIES];
        if (w_idx2[MAX_ENTRIES] == w_idx1[MAX_ENTRIES]) begin
            if (w_idx2[MAX_ENTRIES] < r_count) begin
                w_second_adj = w_idx2[MAX_ENTRIES] + IW'(1);
            end else begin
                w_second_adj = w_idx2[MAX_ENTRIES] - IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (t_func'(i_func))
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                            end
                            FUNC_APPEND: begin
                                if (w_not_full) begin
                                    r_total <= w_total_sum;
                                    r_count <= r_count + IW'(1);
                                end
                            end
                            FUNC_SELECT: begin
                                if (w_empty) begin
                                    r_res_first  <= '0;
                                    r_res_second <= '0;
                                    r_res_failed <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_SCALE;
                                end
                            end
                            default: begin
                                // unused code: no result, no change
                            end
                        endcase
                    end
                end
                S_SCALE: begin
                    if (w_draw_done) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_flags[MAX_ENTRIES].valid) begin
                        r_res_first  <= w_idx1[MAX_ENTRIES];
                        r_res_second <= w_second_adj;
                        r_res_failed <= 1'b0;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_first  <= OUT_INDEX_BITS'(r_res_first);
                        r_out_second <= OUT_INDEX_BITS'(r_res_second);
                        r_out_failed <= r_res_failed;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_first_index  = r_out_first;
    assign o_second_index = r_out_second;
    assign o_failed       = r_out_failed;

    // fill count never passes the store depth
    `RWPS_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || r_count <= IW'(MAX_ENTRIES))
    // a token leaves the chain only during a search, after the full walk
    `RWPS_ASSERT(a_tail_in_scan, i_clk, i_rst_n,
        w_flags[MAX_ENTRIES].valid |-> (r_state == S_SCAN && w_pos[MAX_ENTRIES] == IW'(MAX_ENTRIES)))
    // draws stay below the total, so both picks are always found
    `RWPS_ASSERT(a_tail_found, i_clk, i_rst_n,
        w_flags[MAX_ENTRIES].valid |-> (w_flags[MAX_ENTRIES].found1 && w_flags[MAX_ENTRIES].found2))
    // a good pair is nonzero and distinct
    `RWPS_ASSERT(a_pair_distinct, i_clk, i_rst_n,
        (o_out_valid && !o_failed) |-> (o_first_index != '0 && o_first_index != o_second_index))
    // a failed select reports both indices as zero
    `RWPS_ASSERT(a_fail_zero, i_clk, i_rst_n,
        (o_out_valid && o_failed) |-> (o_first_index == '0 && o_second_index == '0))

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the roulette wheel pair select block
`timescale 1ns / 1ps

module tb;
    import rwps_pkg::*;

    localparam int MAX_ENTRIES   = 256;
    localparam int FITNESS_BITS  = 16;
    localparam int FRACTION_BITS = 16;

    // func code 3 has no name in the package, the block ignores it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // drain a bit longer than a whole select takes
    localparam int DRAIN_CYCLES  = 320;
    // watchdog limit in cycles, with wide margin over the slowest run
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int DIRECTED_ROWS = 25;
    localparam int REPORT_LIMIT  = 10;

    // one result of a select
    typedef struct packed {
        logic [OUT_INDEX_BITS-1:0] first_index;
        logic [OUT_INDEX_BITS-1:0] second_index;
        logic                      failed;
    } t_pick_pair;

    // one row of the directed table; pair is used only where typed is set
    typedef struct packed {
        logic [1:0]               func;
        logic [FITNESS_BITS-1:0]  fitness;
        logic [FRACTION_BITS-1:0] frac_first;
        logic [FRACTION_BITS-1:0] frac_second;
        logic                     typed;
        t_pick_pair               pair;
    } t_stim_row;

    localparam t_pick_pair NO_PAIR     = '0;
    localparam t_pick_pair EMPTY_PAIR  = '{9'd0, 9'd0, 1'b1};
    localparam t_pick_pair SINGLE_PAIR = '{9'd1, 9'd0, 1'b0};

    // dut ports, the inputs all known from time zero
    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      i_in_valid        = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_func            = FUNC_CLEAR;
    logic [FITNESS_BITS-1:0]   i_fitness_value   = '0;
    logic [FRACTION_BITS-1:0]  i_first_fraction  = '0;
    logic [FRACTION_BITS-1:0]  i_second_fraction = '0;
    logic                      o_out_valid;
    logic                      i_out_ready       = 1'b0;
    logic [OUT_INDEX_BITS-1:0] o_first_index;
    logic [OUT_INDEX_BITS-1:0] o_second_index;
    logic                      o_failed;

    // typed expectation riding along with the payload of a directed row
    logic       drv_typed      = 1'b0;
    t_pick_pair drv_typed_pair = NO_PAIR;

    // own copy of the wheel: inclusive prefix sums, fill count and total
    logic [23:0] wheel_prefix [0:MAX_ENTRIES-1];
    logic [8:0]  fill_count  = '0;
    logic [23:0] wheel_total = '0;

    t_pick_pair pending_pairs [$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         items_sent     = 0;
    int         burst_left     = 0;

    t_stim_row  directed_rows [DIRECTED_ROWS];

    // receiver stall pattern, renewed each time the 10-bit phase counter wraps
    logic [31:0] stall_pattern = '1;
    logic [9:0]  stall_phase   = '0;

    roulette_wheel_pair_select #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FITNESS_BITS  (FITNESS_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_fitness_value   (i_fitness_value),
        .i_first_fraction  (i_first_fraction),
        .i_second_fraction (i_second_fraction),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_first_index     (o_first_index),
        .o_second_index    (o_second_index),
        .o_failed          (o_failed)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // one-based index of the first entry whose prefix sum exceeds the scaled draw
    function automatic logic [8:0] spin_pick(logic [FRACTION_BITS-1:0] frac);
        logic [39:0] product;
        logic [23:0] draw;
        product = {24'd0, frac} * {16'd0, wheel_total};
        draw    = product[39:16];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i < fill_count && wheel_prefix[i] > draw) begin
                return 9'(i + 1);
            end
        end
        return 9'd0;
    endfunction

    // fraction with the extremes showing up now and then
    function automatic logic [FRACTION_BITS-1:0] draw_fraction();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return FRACTION_BITS'($urandom);
        endcase
    endfunction

    // fitness flavor per sequence: wide random, tiny (0 to 3), all max, modest (0 to 255)
    function automatic logic [FITNESS_BITS-1:0] draw_fitness(int mode);
        case (mode)
            0: return FITNESS_BITS'($urandom);
            1: return FITNESS_BITS'($urandom_range(0, 3));
            2: return '1;
            default: return FITNESS_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: stalls on a 32-bit pattern, sometimes never
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = '1;
                1: stall_pattern = $urandom;
                default: stall_pattern = $urandom | $urandom;
            endcase
        end
        i_out_ready <= stall_pattern[stall_phase[4:0]];
        stall_phase = stall_phase + 10'd1;
    end

    // predictor and checker: input transfers update the wheel, output
    // transfers are compared with the oldest pending pair
    always @(posedge i_clk) begin
        t_pick_pair pred;
        t_pick_pair want;
        logic [8:0] pick_a;
        logic [8:0] pick_b;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                case (i_func)
                    FUNC_CLEAR: begin
                        fill_count  = '0;
                        wheel_total = '0;
                    end
                    FUNC_APPEND: begin
                        // appends past a full store are dropped
                        if (fill_count < MAX_ENTRIES) begin
                            wheel_total              = wheel_total + 24'(i_fitness_value);
                            wheel_prefix[fill_count] = wheel_total;
                            fill_count               = fill_count + 9'd1;
                        end
                    end
                    FUNC_SELECT: begin
                        if (fill_count == 0 || wheel_total == 0) begin
                            pred = EMPTY_PAIR;
                        end else begin
                            pick_a = spin_pick(i_first_fraction);
                            pick_b = spin_pick(i_second_fraction);
                            // a repeated pick moves up, or down at the last entry
                            if (pick_b == pick_a) begin
                                if (pick_b < fill_count) begin
                                    pick_b = pick_b + 9'd1;
                                end else begin
                                    pick_b = pick_b - 9'd1;
                                end
                            end
                            pred = '{pick_a, pick_b, 1'b0};
                        end
                        pending_pairs.push_back(drv_typed ? drv_typed_pair : pred);
                    end
                    default: begin
                    end
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_pairs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected pair: first %0d second %0d failed %0d",
                                 o_first_index, o_second_index, o_failed);
                    end
                end else begin
                    want = pending_pairs.pop_front();
                    if (o_first_index !== want.first_index ||
                        o_second_index !== want.second_index ||
                        o_failed !== want.failed) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("pair mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.first_index, want.second_index, want.failed,
                                     o_first_index, o_second_index, o_failed);
                        end
                    end
                end
            end
        end
    end

    // sender: bursts of random length, random gaps between them; returns
    // at the edge of the transfer with valid still high
    task automatic send_item(logic [1:0] func, logic [FITNESS_BITS-1:0] fitness,
                             logic [FRACTION_BITS-1:0] frac_a,
                             logic [FRACTION_BITS-1:0] frac_b,
                             logic typed, t_pick_pair pair);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: gap = 0;
                6: gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid        <= 1'b1;
        i_func            <= func;
        i_fitness_value   <= fitness;
        i_first_fraction  <= frac_a;
        i_second_fraction <= frac_b;
        drv_typed         <= typed;
        drv_typed_pair    <= pair;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (func != FUNC_UNUSED) begin
            items_sent++;
        end
    endtask

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[roulette_wheel_pair_select] ERROR");
        $finish;
    end

    initial begin
        int          n_append;
        int          n_select;
        int          mode;
        logic        first_seq;
        logic [1:0]  noise_func;

        // directed part: empty wheel, ignored code, zero total, single
        // entry, extremes of the fractions and of the fitness
        directed_rows = '{
            '{FUNC_SELECT, 16'h0000, 16'h0000, 16'h0000, 1'b1, EMPTY_PAIR},
            '{FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, EMPTY_PAIR},
            '{FUNC_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'h1234, 16'h5678, 1'b1, EMPTY_PAIR},
            '{FUNC_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_APPEND, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, SINGLE_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, SINGLE_PAIR},
            '{FUNC_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_APPEND, 16'h0001, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_APPEND, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'h8000, 16'h7FFF, 1'b0, NO_PAIR},
            '{FUNC_UNUSED, 16'h0001, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'hFFFF, 16'hAAAA, 16'h5555, 1'b0, NO_PAIR},
            '{FUNC_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'h4000, 16'hC000, 1'b1, EMPTY_PAIR},
            '{FUNC_APPEND, 16'h0001, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_APPEND, 16'h0002, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, NO_PAIR},
            '{FUNC_SELECT, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_CLEAR,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
            '{FUNC_APPEND, 16'h8000, 16'h5555, 16'hAAAA, 1'b0, NO_PAIR}
        };

        // single reset at the start
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].func, directed_rows[r].fitness,
                      directed_rows[r].frac_first, directed_rows[r].frac_second,
                      directed_rows[r].typed, directed_rows[r].pair);
        end
        // the last row left a single entry behind
        send_item(FUNC_SELECT, 16'h0000, 16'h5555, 16'hAAAA, 1'b1, SINGLE_PAIR);

        // random part: mostly clear, a run of appends, then a few selects;
        // the first run overfills the store so the full case always shows up
        first_seq = 1'b1;
        while (items_sent < RANDOM_ITEMS + DIRECTED_ROWS) begin
            if (first_seq || $urandom_range(0, 99) < 85) begin
                if (first_seq || $urandom_range(0, 3) != 0) begin
                    send_item(FUNC_CLEAR, FITNESS_BITS'($urandom), draw_fraction(),
                              draw_fraction(), 1'b0, NO_PAIR);
                end
                if (first_seq || $urandom_range(0, 99) == 0) begin
                    n_append = MAX_ENTRIES + $urandom_range(1, 6);
                end else begin
                    n_append = $urandom_range(1, 12);
                end
                mode = first_seq ? 2 : $urandom_range(0, 3);
                repeat (n_append) begin
                    send_item(FUNC_APPEND, draw_fitness(mode), draw_fraction(),
                              draw_fraction(), 1'b0, NO_PAIR);
                end
                n_select = $urandom_range(1, 5);
                repeat (n_select) begin
                    send_item(FUNC_SELECT, FITNESS_BITS'($urandom), draw_fraction(),
                              draw_fraction(), 1'b0, NO_PAIR);
                end
            end else begin
                // noise: any code, including the unused one
                repeat ($urandom_range(1, 4)) begin
                    noise_func = 2'($urandom_range(0, 3));
                    send_item(noise_func, FITNESS_BITS'($urandom), FRACTION_BITS'($urandom),
                              FRACTION_BITS'($urandom), 1'b0, NO_PAIR);
                end
            end
            first_seq = 1'b0;
        end
        i_in_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_pairs.size() == 0) begin
            $display("[roulette_wheel_pair_select] OK");
        end else begin
            $display("[roulette_wheel_pair_select] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rwps_pkg.sv
rtl/rwps_scaler.sv
rtl/rwps_cell.sv
rtl/roulette_wheel_pair_select.sv
sim/tb.sv
